FILE: rtl/core/bdwr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdwr_pkg: shared types and helpers for the draw-without-replacement block
// Word layouts, operation codes, controller command and status bundles, and
// the small bit-count and bit-select functions of the byte scan.
// ----------------------------------------------------------------------------
package bdwr_pkg;

	localparam logic [2:0] OP_DRAW  = 3'd0;
	localparam logic [2:0] OP_CLEAR = 3'd1;
	localparam logic [2:0] OP_LOAD  = 3'd2;
	localparam logic [2:0] OP_MARK  = 3'd3;
	localparam logic [2:0] OP_QUERY = 3'd4;

	typedef struct packed {
		logic [2:0] operation;
		logic [8:0] rank;
		logic [8:0] item_index;
		logic [5:0] byte_address;
		logic [7:0] byte_value;
	} req_word_t;

	typedef struct packed {
		logic [8:0] drawn_item;
		logic [9:0] unused_count;
		logic       used_flag;
	} rsp_word_t;

	typedef struct packed {
		logic capture;
		logic sweep;
		logic set_full;
		logic rd_single;
		logic update;
		logic prep;
		logic scan;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic count_zero;
		logic found;
		logic out_free;
	} sts_t;

	function automatic logic [3:0] popcount8(input logic [7:0] v);
		logic [3:0] c;
		c = 4'd0;
		for (int k = 0; k < 8; k++)
			c = c + {3'b000, v[k]};
		return c;
	endfunction

	// position of the n-th set bit of v, counting from bit zero
	function automatic logic [2:0] nth_set(input logic [7:0] v, input logic [2:0] n);
		logic [3:0] seen;
		logic [2:0] pos;
		seen = 4'd0;
		pos  = 3'd0;
		for (int k = 0; k < 8; k++) begin
			if (v[k]) begin
				if (seen == {1'b0, n})
					pos = 3'(k);
				seen = seen + 4'd1;
			end
		end
		return pos;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bdwr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdwr_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bdwr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/core/bdwr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdwr_ctrl: operation sequencer
// Accepts one request word at a time and steps the datapath through sweep,
// single-byte update or rank scan, then hands the result to the output stage.
// ----------------------------------------------------------------------------
module bdwr_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	input  wire logic [2:0]      op,
	output logic                 req_stall,
	input  wire bdwr_pkg::sts_t  sts,
	output bdwr_pkg::cmd_t       cmd
);
	import bdwr_pkg::*;

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_READ   = 7'b0000100,
		S_UPDATE = 7'b0001000,
		S_PREP   = 7'b0010000,
		S_SCAN   = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   pend_q, pend_d;
	logic   reply_q, reply_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		pend_d  = pend_q;
		reply_d = reply_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					cmd.set_full = 1'b1;
					pend_d       = 1'b0;
					reply_d      = 1'b0;
					if (pend_q)
						state_d = S_PREP;
					else if (reply_q)
						state_d = S_DONE;
					else
						state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					unique case (op)
						OP_DRAW: begin
							pend_d  = sts.count_zero;
							reply_d = 1'b1;
							state_d = sts.count_zero ? S_CLEAR : S_PREP;
						end
						OP_CLEAR: begin
							pend_d  = 1'b0;
							reply_d = 1'b1;
							state_d = S_CLEAR;
						end
						OP_LOAD, OP_MARK, OP_QUERY: state_d = S_READ;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_READ: begin
				cmd.rd_single = 1'b1;
				state_d       = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_DONE;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.found)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			pend_q  <= 1'b0;
			reply_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			reply_q <= reply_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/bdwr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdwr_dp: used-map datapath
// Map RAM, unused-item count, rank scan over map bytes, single-byte update
// and the output register.
// ----------------------------------------------------------------------------
module bdwr_dp #(
	parameter int ITEM_COUNT = 512,
	parameter int MAP_BYTES  = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bdwr_pkg::req_word_t req,
	input  wire bdwr_pkg::cmd_t      cmd,
	output bdwr_pkg::sts_t           sts,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output bdwr_pkg::rsp_word_t      rsp
);
	import bdwr_pkg::*;

	localparam int LIM = (ITEM_COUNT < MAP_BYTES * 8) ? ITEM_COUNT : MAP_BYTES * 8;
	localparam int AW  = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int CW  = $clog2(LIM + 1);

	function automatic logic [7:0] vmask(input logic [AW-1:0] b);
		logic [7:0] m;
		int         base;
		base = int'(b) * 8;
		for (int k = 0; k < 8; k++)
			m[k] = (base + k) < LIM;
		return m;
	endfunction

	// captured request
	logic [2:0]    op_q;
	logic [8:0]    rank_q;
	logic [8:0]    idx_q;
	logic [5:0]    addr_q;
	logic [7:0]    value_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] r_q;
	logic [AW-1:0] wa_q;
	logic [AW-1:0] ra_q;
	logic [AW-1:0] eb_s1;
	logic          rdv_s1;
	logic [8:0]    drawn_q;
	logic          flag_q;
	logic          out_valid_q;
	rsp_word_t     out_q;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;

	bdwr_ram #(
		.WIDTH(8),
		.DEPTH(MAP_BYTES),
		.AW   (AW)
	) u_map (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// single-byte operations
	logic [AW-1:0] sel_addr;
	logic          idx_ok, addr_ok, cur_bit;
	logic [7:0]    load_v, mark_v;
	logic [CW:0]   load_cnt;

	assign sel_addr = (op_q == OP_LOAD) ? AW'(addr_q) : AW'(idx_q[8:3]);
	assign idx_ok   = 32'(idx_q) < LIM;
	assign addr_ok  = 32'(addr_q) < MAP_BYTES;
	assign cur_bit  = rdata[idx_q[2:0]];
	assign load_v   = value_q & vmask(AW'(addr_q));
	assign mark_v   = rdata | (8'd1 << idx_q[2:0]);
	assign load_cnt = (CW+1)'(count_q) + (CW+1)'(popcount8(rdata))
		- (CW+1)'(popcount8(load_v));

	// rank scan
	logic [7:0]    free_v;
	logic [3:0]    free_cnt;
	logic          hit;
	logic [2:0]    hit_bit;
	logic [CW+8:0] rank_x, cnt_x;
	logic [CW-1:0] r_sat;

	assign free_v   = ~rdata & vmask(eb_s1);
	assign free_cnt = popcount8(free_v);
	assign hit      = (CW+4)'(r_q) < (CW+4)'(free_cnt);
	assign hit_bit  = nth_set(free_v, 3'(r_q));
	assign rank_x   = (CW+9)'(rank_q);
	assign cnt_x    = (CW+9)'(count_q);
	assign r_sat    = (rank_x >= cnt_x) ? count_q - CW'(1) : CW'(rank_q);

	assign sts.sweep_last = (wa_q == AW'(MAP_BYTES - 1));
	assign sts.count_zero = (count_q == '0);
	assign sts.found      = rdv_s1 & hit;
	assign sts.out_free   = !out_valid_q || !rsp_stall;

	always_comb begin
		we    = 1'b0;
		waddr = sel_addr;
		wdata = 8'd0;
		priority if (cmd.sweep) begin
			we    = 1'b1;
			waddr = wa_q;
		end else if (cmd.update) begin
			unique case (op_q)
				OP_LOAD: begin
					we    = addr_ok;
					wdata = load_v;
				end
				OP_MARK: begin
					we    = idx_ok & !cur_bit;
					wdata = mark_v;
				end
				default: we = 1'b0;
			endcase
		end else if (cmd.scan && rdv_s1 && hit) begin
			we    = 1'b1;
			waddr = eb_s1;
			wdata = rdata | (8'd1 << hit_bit);
		end else begin
			we = 1'b0;
		end
	end

	assign re    = cmd.rd_single | cmd.scan;
	assign raddr = cmd.scan ? ra_q : sel_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CW'(LIM);
			wa_q        <= '0;
			ra_q        <= '0;
			rdv_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.sweep)
				wa_q <= sts.sweep_last ? '0 : wa_q + AW'(1);
			if (cmd.prep)
				ra_q <= '0;
			else if (cmd.scan)
				ra_q <= ra_q + AW'(1);
			rdv_s1 <= cmd.scan;
			priority if (cmd.set_full)
				count_q <= CW'(LIM);
			else if (cmd.update && op_q == OP_LOAD && addr_ok)
				count_q <= CW'(load_cnt);
			else if (cmd.update && op_q == OP_MARK && idx_ok && !cur_bit)
				count_q <= count_q - CW'(1);
			else if (cmd.scan && rdv_s1 && hit)
				count_q <= count_q - CW'(1);
			else
				count_q <= count_q;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (!rsp_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= req.operation;
			rank_q  <= req.rank;
			idx_q   <= req.item_index;
			addr_q  <= req.byte_address;
			value_q <= req.byte_value;
			drawn_q <= 9'd0;
			flag_q  <= 1'b0;
		end
		if (cmd.prep)
			r_q <= r_sat;
		else if (cmd.scan && rdv_s1 && !hit)
			r_q <= r_q - CW'(free_cnt);
		if (cmd.scan)
			eb_s1 <= ra_q;
		if (cmd.scan && rdv_s1 && hit)
			drawn_q <= 9'({eb_s1, hit_bit});
		if (cmd.update && op_q == OP_QUERY)
			flag_q <= !idx_ok || cur_bit;
		if (cmd.finish) begin
			out_q.drawn_item   <= drawn_q;
			out_q.unused_count <= 10'(count_q);
			out_q.used_flag    <= flag_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
`default_nettype wire

FILE: rtl/core/bitmap_draw_without_replacement.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_draw_without_replacement: used-item map with draw by rank
// Draws the rank-th unused item and marks it used; also clears, loads,
// marks and queries the map, reporting the unused count after each word.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | word
//  req      | in        | req_valid / req_stall  | operation, rank, item_index,
//           |           |                        | byte_address, byte_value
//  rsp      | out       | rsp_valid / rsp_stall  | drawn_item, unused_count, used_flag
//
//  One request word is in flight at a time; the map RAM gives one byte per cycle.
//  Load, mark, query: read the byte, then update it. Unknown operation: result only.
//  Clear: a zeroing sweep of all MAP_BYTES bytes. Draw: scans the map bytes in order
//  from byte zero up to the hit byte; on an exhausted map a zeroing sweep runs first.
//  After reset the same sweep runs before the first word is taken.
//  A stalled result sits in the output register while the next word is accepted.
// ----------------------------------------------------------------------------
module bitmap_draw_without_replacement #(
	parameter int ITEM_COUNT = 512,
	parameter int MAP_BYTES  = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire bdwr_pkg::req_word_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output bdwr_pkg::rsp_word_t      rsp
);
	import bdwr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bdwr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.op       (req.operation),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bdwr_dp #(
		.ITEM_COUNT(ITEM_COUNT),
		.MAP_BYTES (MAP_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire
